>>> hdl/rcfb_pkg.sv
// Shared types, constants and CRC helper for the rotation command frame builder.
package rcfb_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgDevAddr  = 2'd0,
    CfgTurnsReg = 2'd1,
    CfgAngleReg = 2'd2
  } cfg_idx_e;

  // Byte positions inside one 13-byte frame
  typedef enum logic [3:0] {
    PosAddr    = 4'd0,
    PosFunc    = 4'd1,
    PosRegHi   = 4'd2,
    PosRegLo   = 4'd3,
    PosCntHi   = 4'd4,
    PosCntLo   = 4'd5,
    PosByteCnt = 4'd6,
    PosW0Hi    = 4'd7,
    PosW0Lo    = 4'd8,
    PosW1Hi    = 4'd9,
    PosW1Lo    = 4'd10,
    PosCrcLo   = 4'd11,
    PosCrcHi   = 4'd12
  } frame_pos_e;

  // Reset values of the configuration registers
  localparam logic [7:0]  DevAddrRst  = 8'd1;
  localparam logic [15:0] TurnsRegRst = 16'd29002;
  localparam logic [15:0] AngleRegRst = 16'd29003;

  // Frame constants
  localparam logic [7:0]  FuncWriteMulti = 8'h10;
  localparam logic [7:0]  RegCountHi     = 8'h00;
  localparam logic [7:0]  RegCountLo     = 8'h02;
  localparam logic [7:0]  DataByteCnt    = 8'h04;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;
  localparam int unsigned FrameLen       = 13;
  localparam int unsigned TotalBytes     = 2 * FrameLen;

  // Floor division by 360: bias the input by 360*TurnBias to make it positive,
  // then divide by 8 (shift) and by 45 via reciprocal multiply.
  localparam logic [32:0] DegOffset  = 33'd2147483880;
  localparam logic [31:0] TurnBias   = 32'd5965233;
  localparam logic [30:0] Recip45    = 31'd1527099484;  // ceil(2^36 / 45)
  localparam int unsigned RecipShift = 36;
  localparam int unsigned FracShift  = RecipShift - 13;  // times 8192, over 2^36

  // One byte of CRC-16/MODBUS
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/rotation_command_frame_builder_unit.sv
// Top level: rotation split into turns and angle, serialized as two Modbus RTU frames.
// Path: the start transaction registers the command, then stages s0..s3 lead to the
// first frame byte; the 26 bytes follow back to back with strobe_o high.
// Rate: the output runs at one byte per cycle with no stall; the next start is taken
// while the last 5 bytes of the previous command go out.
// Reset: rst_ni clears the stage valids and serializer; config returns to defaults.
module rotation_command_frame_builder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] rotation_degrees_i,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // result bytes
  output logic        strobe_o,
  output logic [7:0]  frame_byte_o,
  output logic        frame_kind_o,
  output logic        last_byte_o
);
  import rcfb_pkg::*;

  localparam int unsigned CntW = $clog2(TotalBytes);
  localparam logic [CntW-1:0] LastCnt  = CntW'(TotalBytes - 1);
  localparam logic [CntW-1:0] StartCnt = CntW'(TotalBytes - 5);
  localparam logic [CntW-1:0] Frame1   = CntW'(FrameLen);

  // configuration registers
  logic [7:0]  dev_addr_q;
  logic [15:0] turns_reg_q, angle_reg_q;

  // pipeline registers
  logic        s0_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic [31:0] deg_q;
  logic [24:0] quo_q;
  logic [32:0] biased_q;
  logic [8:0]  rem_q;
  logic [31:0] turns2_q, turns3_q, turns_q;
  logic [15:0] frac3_q, frac_q;

  // serializer registers
  logic            act_q;
  logic [CntW-1:0] cnt_q;
  logic [15:0]     crc_q, crc_d;

  logic        accept;
  logic [32:0] biased_d;
  logic [60:0] quo_prod;
  logic [32:0] rem_full;
  logic [39:0] frac_prod;

  logic        kind;
  logic [3:0]  pos;
  logic [15:0] reg_sel, w0, w1;
  logic [7:0]  byte_d;

  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign busy_o      = s0_v_q || s1_v_q || s2_v_q || s3_v_q || (act_q && (cnt_q < StartCnt));

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrRst;
      turns_reg_q <= TurnsRegRst;
      angle_reg_q <= AngleRegRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDevAddr:  dev_addr_q  <= cfg_data_i[7:0];
        CfgTurnsReg: turns_reg_q <= cfg_data_i;
        CfgAngleReg: angle_reg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // datapath: bias, reciprocal multiply, remainder, fraction scaling
  assign biased_d  = {deg_q[31], deg_q} + DegOffset;
  assign quo_prod  = 61'(biased_d[32:3]) * 61'(Recip45);
  assign rem_full  = biased_q - (33'(quo_q) * 33'd360);
  assign frac_prod = 40'(rem_q) * 40'(Recip45);

  always_ff @(posedge clk_i) begin
    if (accept) deg_q <= rotation_degrees_i;
    biased_q <= biased_d;
    quo_q    <= quo_prod[60:RecipShift];
    rem_q    <= rem_full[8:0];
    turns2_q <= 32'(quo_q) - TurnBias;
    turns3_q <= turns2_q;
    frac3_q  <= frac_prod[FracShift+15:FracShift];
    if (s3_v_q) begin
      turns_q <= turns3_q;
      frac_q  <= frac3_q;
    end
  end

  // byte selection for the current position
  assign kind    = (cnt_q >= Frame1);
  assign pos     = kind ? 4'(cnt_q - Frame1) : 4'(cnt_q);
  assign reg_sel = kind ? angle_reg_q : turns_reg_q;
  assign w0      = kind ? 16'h0000 : turns_q[15:0];
  assign w1      = kind ? frac_q : turns_q[31:16];

  always_comb begin
    case (frame_pos_e'(pos))
      PosAddr:    byte_d = dev_addr_q;
      PosFunc:    byte_d = FuncWriteMulti;
      PosRegHi:   byte_d = reg_sel[15:8];
      PosRegLo:   byte_d = reg_sel[7:0];
      PosCntHi:   byte_d = RegCountHi;
      PosCntLo:   byte_d = RegCountLo;
      PosByteCnt: byte_d = DataByteCnt;
      PosW0Hi:    byte_d = w0[15:8];
      PosW0Lo:    byte_d = w0[7:0];
      PosW1Hi:    byte_d = w1[15:8];
      PosW1Lo:    byte_d = w1[7:0];
      PosCrcLo:   byte_d = crc_q[7:0];
      PosCrcHi:   byte_d = crc_q[15:8];
      default:    byte_d = 8'h00;
    endcase
  end

  // running CRC: preset at frame start, updated over the first 11 bytes
  always_comb begin
    crc_d = crc_q;
    if (s3_v_q || frame_pos_e'(pos) == PosCrcHi) begin
      crc_d = CrcInit;
    end else if (act_q && pos < 4'(PosCrcLo)) begin
      crc_d = crc16_byte(crc_q, byte_d);
    end
  end

  // serializer counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
      if (s3_v_q) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        if (cnt_q == LastCnt) begin
          act_q <= 1'b0;
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // result outputs
  assign strobe_o     = act_q;
  assign frame_byte_o = byte_d;
  assign frame_kind_o = kind;
  assign last_byte_o  = act_q && (cnt_q == LastCnt);

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the rotation command frame builder (turn and angle frames).
module tb_top;
  import rcfb_pkg::*;

  // Register index that maps to no register; writes to it must be ignored
  localparam logic [1:0] CfgNoReg = 2'd3;

  // One expected output byte
  typedef struct packed {
    logic [7:0] value;
    logic       kind;
    logic       last;
  } frame_byte_t;

  // Predicts both frames of each accepted command and checks the bytes in order
  class frame_byte_checker;
    logic [7:0]  dev_addr  = DevAddrRst;
    logic [15:0] turns_reg = TurnsRegRst;
    logic [15:0] angle_reg = AngleRegRst;
    frame_byte_t pending_bytes[$];
    int          errors = 0;

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CfgDevAddr:  dev_addr  = data[7:0];
        CfgTurnsReg: turns_reg = data;
        CfgAngleReg: angle_reg = data;
        default: ;
      endcase
    endfunction

    // CRC-16/MODBUS, shifted one bit at a time, LSB first
    function logic [15:0] modbus_crc(logic [7:0] body[11]);
      logic [15:0] crc;
      logic        fb;
      crc = CrcInit;
      foreach (body[i]) begin
        for (int b = 0; b < 8; b++) begin
          fb  = crc[0] ^ body[i][b];
          crc = crc >> 1;
          if (fb) crc = crc ^ CrcPoly;
        end
      end
      return crc;
    endfunction

    function void push_frame(logic [15:0] reg_addr, logic [15:0] w0, logic [15:0] w1,
                             logic kind);
      logic [7:0]  body[11];
      logic [15:0] crc;
      logic [7:0]  bytes[13];
      body = '{dev_addr, FuncWriteMulti, reg_addr[15:8], reg_addr[7:0], RegCountHi,
               RegCountLo, DataByteCnt, w0[15:8], w0[7:0], w1[15:8], w1[7:0]};
      crc = modbus_crc(body);
      foreach (body[i]) bytes[i] = body[i];
      bytes[11] = crc[7:0];
      bytes[12] = crc[15:8];
      foreach (bytes[i]) begin
        pending_bytes.push_back('{bytes[i], kind, kind && (i == FrameLen - 1)});
      end
    endfunction

    // Floor split into turns and 0..359 degrees, then the two frames
    function void note_rotation(logic [31:0] deg_bits);
      longint      deg;
      longint      whole;
      longint      rem;
      logic [31:0] turns;
      logic [15:0] frac;
      deg   = longint'($signed(deg_bits));
      whole = deg / 360;
      rem   = deg % 360;
      if (rem < 0) begin
        rem   += 360;
        whole -= 1;
      end
      turns = whole[31:0];
      frac  = 16'((rem * 65536) / 360);
      push_frame(turns_reg, turns[15:0], turns[31:16], 1'b0);
      push_frame(angle_reg, 16'h0000, frac, 1'b1);
    endfunction

    function void check_frame_byte(logic [7:0] value, logic kind, logic last);
      frame_byte_t want;
      if (pending_bytes.size() == 0) begin
        flag($sformatf("unexpected byte %02h kind %0d last %0d", value, kind, last));
        return;
      end
      want = pending_bytes.pop_front();
      if (want.value !== value || want.kind !== kind || want.last !== last) begin
        flag($sformatf("expected byte %02h kind %0d last %0d, got %02h kind %0d last %0d",
                       want.value, want.kind, want.last, value, kind, last));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] rotation_degrees_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        strobe_o;
  logic [7:0]  frame_byte_o;
  logic        frame_kind_o;
  logic        last_byte_o;

  frame_byte_checker frames = new();

  rotation_command_frame_builder_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .rotation_degrees_i (rotation_degrees_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .strobe_o           (strobe_o),
    .frame_byte_o       (frame_byte_o),
    .frame_kind_o       (frame_kind_o),
    .last_byte_o        (last_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor: result bytes first, then accepted commands and register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) frames.check_frame_byte(frame_byte_o, frame_kind_o, last_byte_o);
      if (start_i && !busy_o) frames.note_rotation(rotation_degrees_i);
      if (cfg_valid_i && cfg_ready_o) frames.set_reg(cfg_index_i, cfg_data_i);
    end
  end

  // Hold start and data through the command transaction until busy_o falls; start stays high
  task automatic send_rotation(input logic [31:0] deg, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i            <= 1'b1;
    rotation_degrees_i <= deg;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Valid stays high after the transaction; caller lowers it after the batch
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] addr, input logic [15:0] treg,
                          input logic [15:0] areg);
    write_reg(CfgDevAddr, addr);
    write_reg(CfgTurnsReg, treg);
    write_reg(CfgAngleReg, areg);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending and wait until every predicted byte has come out
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (frames.pending() != 0) @(posedge clk_i);
  endtask

  // Mix of full-range values, small angles and values near whole turns
  function automatic logic [31:0] pick_rotation();
    int k;
    case ($urandom_range(0, 3))
      0, 1: return $urandom();
      2: begin
        k = int'($urandom_range(0, 2880)) - 1440;
        return k;
      end
      default: begin
        k = int'($urandom_range(0, 20000)) - 10000;
        return k * 360 + int'($urandom_range(0, 2)) - 1;
      end
    endcase
  endfunction

  task automatic run_random(input int count, input int idle_pct);
    repeat (count) send_rotation(pick_rotation(), idle_pct);
  endtask

  // Directed values: sign edges, turn boundaries, field extremes
  logic [31:0] directed_rot[] = '{32'd0, 32'd1, -32'sd1, -32'sd2, 32'd359, 32'd360,
                                  -32'sd360, -32'sd359, -32'sd361, 32'd719, 32'd720,
                                  32'd180, 32'd90, 32'h7FFFFFFF, 32'h80000000,
                                  32'd23592960, -32'sd23592960, -32'sd23592961,
                                  32'd12345678, -32'sd12345678, 32'hFFFF0000};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values
    foreach (directed_rot[i]) send_rotation(directed_rot[i], 0);
    drain();

    // Low extremes, plus a write to the unused index
    write_reg(CfgNoReg, 16'($urandom()));
    set_regs(16'h0000, 16'h0000, 16'h0000);
    run_random(60, 0);
    drain();

    // High extremes; upper data bits of the address write are dropped
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(70, 79);
    drain();

    set_regs(16'($urandom()), 16'($urandom()), 16'($urandom()));
    run_random(80, 17);
    drain();

    set_regs(16'($urandom()), 16'($urandom()), 16'($urandom()));
    run_random(70, 0);
    drain();

    repeat (10) @(posedge clk_i);
    if (frames.pending() != 0) frames.flag($sformatf("%0d bytes never came", frames.pending()));
    if (frames.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> rotation_command_frame_builder_unit.f
hdl/rcfb_pkg.sv
hdl/rotation_command_frame_builder_unit.sv
sim/tb_top.sv
